// ===== rtl/vrth_pkg.sv =====
// ----------------------------------------------------------------------------
// vrth_pkg
// Shared types and constants of the vertical ray / triangle hit block.
// ----------------------------------------------------------------------------
package vrth_pkg;

    // configuration port
    localparam int DATA_W       = 32;
    localparam int ADDR_W       = 3;
    localparam int REG_IDX_LSB  = 2;
    localparam logic [ADDR_W-REG_IDX_LSB-1:0] REG_HALF_SPAN = 1'b0;

    // half span register
    localparam int SPAN_W     = 24;
    localparam int SPAN_UNITS = 100;

    // classification made by the front end
    typedef enum logic [1:0] {
        CLS_NORMAL,
        CLS_OUTSIDE,
        CLS_DEGEN
    } cls_t;

    // result reason code
    typedef enum logic [2:0] {
        OUT_HIT     = 3'd0,
        OUT_OUTSIDE = 3'd1,
        OUT_DEGEN   = 3'd2,
        OUT_BELOW   = 3'd3,
        OUT_ABOVE   = 3'd4
    } outcome_t;

    // queue status seen by both ends
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ===== rtl/vrth_in_if.sv =====
// ----------------------------------------------------------------------------
// vrth_in_if
// Input channel: one triangle and one query point per word.
// ----------------------------------------------------------------------------
interface vrth_in_if #(
    parameter int COORD_BITS = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] v0_x;
    logic signed [COORD_BITS-1:0] v0_y;
    logic signed [COORD_BITS-1:0] v0_z;
    logic signed [COORD_BITS-1:0] v1_x;
    logic signed [COORD_BITS-1:0] v1_y;
    logic signed [COORD_BITS-1:0] v1_z;
    logic signed [COORD_BITS-1:0] v2_x;
    logic signed [COORD_BITS-1:0] v2_y;
    logic signed [COORD_BITS-1:0] v2_z;
    logic signed [COORD_BITS-1:0] query_x;
    logic signed [COORD_BITS-1:0] query_y;
    logic signed [COORD_BITS-1:0] query_z;

    modport source (
        output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
               query_x, query_y, query_z,
        input  ready
    );
    modport sink (
        input  valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
               query_x, query_y, query_z,
        output ready
    );
endinterface

// ===== rtl/vrth_out_if.sv =====
// ----------------------------------------------------------------------------
// vrth_out_if
// Result channel: hit flag, hit height and reason code per word.
// ----------------------------------------------------------------------------
interface vrth_out_if #(
    parameter int COORD_BITS = 32
);
    logic                         valid;
    logic                         ready;
    logic                         hit;
    logic signed [COORD_BITS-1:0] hit_z;
    logic [2:0]                   outcome;

    modport source (
        output valid, hit, hit_z, outcome,
        input  ready
    );
    modport sink (
        input  valid, hit, hit_z, outcome,
        output ready
    );
endinterface

// ===== rtl/vrth_front.sv =====
// ----------------------------------------------------------------------------
// vrth_front
// Front end: edge functions, plane normal and classification, three stages.
// ----------------------------------------------------------------------------
module vrth_front #(
    parameter int COORD_BITS = 32,
    localparam int W     = COORD_BITS,
    localparam int DW    = W + 1,
    localparam int NW    = 2 * DW + 1,
    localparam int ENT_W = 2 + 3 * NW + 2 * DW + 2 * W
) (
    input  logic               clk,
    input  logic               rst_n,
    vrth_in_if.sink            tri_in,
    output logic               push,
    output logic [ENT_W-1:0]   push_data,
    input  vrth_pkg::q_stat_t  q_stat
);
    import vrth_pkg::*;

    localparam int PW = 2 * DW;

    typedef struct packed {
        cls_t                 cls;
        logic signed [NW-1:0] nx;
        logic signed [NW-1:0] ny;
        logic signed [NW-1:0] nz;
        logic signed [DW-1:0] px;
        logic signed [DW-1:0] py;
        logic signed [W-1:0]  v0z;
        logic signed [W-1:0]  qz;
    } ent_t;

    function automatic logic signed [DW-1:0] dif(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
        return DW'(a) - DW'(b);
    endfunction

    function automatic logic signed [NW-1:0] pdif(input logic signed [PW-1:0] a,
                                                  input logic signed [PW-1:0] b);
        return NW'(a) - NW'(b);
    endfunction

    logic adv;

    logic signed [W-1:0] vx [3];
    logic signed [W-1:0] vy [3];
    logic signed [W-1:0] nvx [3];
    logic signed [W-1:0] nvy [3];

    // stage 1: differences
    logic                 f1_valid_reg;
    logic signed [DW-1:0] ed_x_reg [3];
    logic signed [DW-1:0] ed_y_reg [3];
    logic signed [DW-1:0] ep_x_reg [3];
    logic signed [DW-1:0] ep_y_reg [3];
    logic signed [DW-1:0] e1z_reg, e2x_reg, e2y_reg, e2z_reg;
    logic signed [W-1:0]  f1_v0z_reg, f1_qz_reg;

    // stage 2: products
    logic                 f2_valid_reg;
    logic signed [PW-1:0] ea_reg [3];
    logic signed [PW-1:0] eb_reg [3];
    logic signed [PW-1:0] nxa_reg, nxb_reg, nya_reg, nyb_reg, nza_reg, nzb_reg;
    logic signed [DW-1:0] f2_px_reg, f2_py_reg;
    logic signed [W-1:0]  f2_v0z_reg, f2_qz_reg;

    // stage 3: classified entry
    logic                 f3_valid_reg;
    ent_t                 ent_reg;
    ent_t                 ent_next;
    logic                 outside;
    logic signed [NW-1:0] ev [3];

    assign vx[0]  = tri_in.v0_x;
    assign vx[1]  = tri_in.v1_x;
    assign vx[2]  = tri_in.v2_x;
    assign vy[0]  = tri_in.v0_y;
    assign vy[1]  = tri_in.v1_y;
    assign vy[2]  = tri_in.v2_y;
    assign nvx[0] = tri_in.v1_x;
    assign nvx[1] = tri_in.v2_x;
    assign nvx[2] = tri_in.v0_x;
    assign nvy[0] = tri_in.v1_y;
    assign nvy[1] = tri_in.v2_y;
    assign nvy[2] = tri_in.v0_y;

    // hold the whole front while a valid entry waits on a full queue
    assign adv          = !(f3_valid_reg && q_stat.full);
    assign tri_in.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            f1_valid_reg <= tri_in.valid;
            f2_valid_reg <= f1_valid_reg;
            f3_valid_reg <= f2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                ed_x_reg[k] <= dif(nvx[k], vx[k]);
                ed_y_reg[k] <= dif(nvy[k], vy[k]);
                ep_x_reg[k] <= dif(tri_in.query_x, vx[k]);
                ep_y_reg[k] <= dif(tri_in.query_y, vy[k]);
            end
            e1z_reg    <= dif(tri_in.v1_z, tri_in.v0_z);
            e2x_reg    <= dif(tri_in.v2_x, tri_in.v0_x);
            e2y_reg    <= dif(tri_in.v2_y, tri_in.v0_y);
            e2z_reg    <= dif(tri_in.v2_z, tri_in.v0_z);
            f1_v0z_reg <= tri_in.v0_z;
            f1_qz_reg  <= tri_in.query_z;

            for (int k = 0; k < 3; k++)
            begin
                ea_reg[k] <= PW'(ed_x_reg[k]) * PW'(ep_y_reg[k]);
                eb_reg[k] <= PW'(ed_y_reg[k]) * PW'(ep_x_reg[k]);
            end
            // edge 0 differences are e1.x and e1.y
            nxa_reg    <= PW'(ed_y_reg[0]) * PW'(e2z_reg);
            nxb_reg    <= PW'(e1z_reg) * PW'(e2y_reg);
            nya_reg    <= PW'(e1z_reg) * PW'(e2x_reg);
            nyb_reg    <= PW'(ed_x_reg[0]) * PW'(e2z_reg);
            nza_reg    <= PW'(ed_x_reg[0]) * PW'(e2y_reg);
            nzb_reg    <= PW'(ed_y_reg[0]) * PW'(e2x_reg);
            f2_px_reg  <= ep_x_reg[0];
            f2_py_reg  <= ep_y_reg[0];
            f2_v0z_reg <= f1_v0z_reg;
            f2_qz_reg  <= f1_qz_reg;

            ent_reg <= ent_next;
        end
    end

    always_comb
    begin
        outside = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            ev[k]   = pdif(ea_reg[k], eb_reg[k]);
            outside = outside | ev[k][NW-1];
        end
        ent_next.nx  = pdif(nxa_reg, nxb_reg);
        ent_next.ny  = pdif(nya_reg, nyb_reg);
        ent_next.nz  = pdif(nza_reg, nzb_reg);
        ent_next.px  = f2_px_reg;
        ent_next.py  = f2_py_reg;
        ent_next.v0z = f2_v0z_reg;
        ent_next.qz  = f2_qz_reg;
        priority if (outside)
            ent_next.cls = CLS_OUTSIDE;
        else if (nza_reg == nzb_reg)
            ent_next.cls = CLS_DEGEN;
        else
            ent_next.cls = CLS_NORMAL;
    end

    assign push      = f3_valid_reg && !q_stat.full;
    assign push_data = ENT_W'(ent_reg);

endmodule

// ===== rtl/vrth_queue.sv =====
// ----------------------------------------------------------------------------
// vrth_queue
// Short FIFO between front and back end.
// ----------------------------------------------------------------------------
module vrth_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [DATA_W-1:0]  push_data,
    input  logic               pop,
    output logic [DATA_W-1:0]  pop_data,
    output vrth_pkg::q_stat_t  q_stat
);
    import vrth_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  cnt_reg;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= bump(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= bump(rd_ptr_reg);
            unique case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    assign pop_data     = mem[rd_ptr_reg];
    assign q_stat.full  = (cnt_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (cnt_reg == '0);

endmodule

// ===== rtl/vrth_back.sv =====
// ----------------------------------------------------------------------------
// vrth_back
// Back end: plane numerator, pipelined rounding divide, span test, result.
// ----------------------------------------------------------------------------
module vrth_back #(
    parameter int COORD_BITS = 32,
    localparam int W     = COORD_BITS,
    localparam int DW    = W + 1,
    localparam int NW    = 2 * DW + 1,
    localparam int ENT_W = 2 + 3 * NW + 2 * DW + 2 * W
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [vrth_pkg::SPAN_W-1:0]  half_span,
    input  vrth_pkg::q_stat_t            q_stat,
    output logic                         pop,
    input  logic [ENT_W-1:0]             pop_data,
    vrth_out_if.source                   hit_out
);
    import vrth_pkg::*;

    localparam int S    = DW;                       // low split of a normal
    localparam int NUMW = 3 * W + 6;                // plane numerator
    localparam int Q    = ((W > SPAN_W) ? W : SPAN_W) + 4;  // quotient bits
    localparam int DVW  = NW + 1;                   // divisor 2*|nz|
    localparam int RA   = NUMW + 2;
    localparam int RB   = DVW + Q;
    localparam int R_W  = (RA > RB) ? RA : RB;
    localparam int HB   = Q + 3;                    // height and bounds

    typedef struct packed {
        cls_t                 cls;
        logic signed [NW-1:0] nx;
        logic signed [NW-1:0] ny;
        logic signed [NW-1:0] nz;
        logic signed [DW-1:0] px;
        logic signed [DW-1:0] py;
        logic signed [W-1:0]  v0z;
        logic signed [W-1:0]  qz;
    } ent_t;

    typedef struct packed {
        cls_t                cls;
        logic                nz_neg;
        logic                neg;
        logic                ovf;
        logic signed [W-1:0] v0z;
        logic signed [W-1:0] qz;
    } side_t;

    logic adv;
    ent_t ent;

    // stage 1: partial products
    logic                 b1_valid_reg;
    logic signed [NW-1:0] pp_lx_reg, pp_hx_reg, pp_ly_reg, pp_hy_reg;
    logic signed [NW-1:0] b1_nz_reg;
    side_t                b1_side_reg;
    // stage 2: per-axis sums
    logic                   b2_valid_reg;
    logic signed [NUMW-1:0] sx_reg, sy_reg;
    logic signed [NW-1:0]   b2_nz_reg;
    side_t                  b2_side_reg;
    // stage 3: numerator and divisor magnitude
    logic                   b3_valid_reg;
    logic signed [NUMW-1:0] num_reg;
    logic [NW-1:0]          den_reg;
    side_t                  b3_side_reg;
    // divider array; entry 0 is the range check stage
    logic                   b4_valid_reg;
    logic [R_W-1:0]         b4_n_reg;
    logic [DVW-1:0]         b4_d_reg;
    side_t                  b4_side_reg;
    side_t                  b4_side_next;
    side_t                  div_s0_next;
    logic [NUMW-1:0]        num_mag;

    logic                   div_v [0:Q];
    side_t                  div_s [0:Q];
    logic [Q-1:0]           div_q [0:Q];
    logic [R_W-1:0]         div_r [0:Q-1];
    logic [DVW-1:0]         div_d [0:Q-1];

    // stage E: height and bounds
    logic                   e_valid_reg;
    logic signed [HB-1:0]   h_reg, lo_reg, hi_reg;
    cls_t                   e_cls_reg;
    logic [Q:0]             qmag;
    logic signed [HB-1:0]   span_s;

    // output register
    logic                   o_valid_reg;
    logic                   o_hit_reg;
    logic signed [W-1:0]    o_z_reg;
    outcome_t               o_outcome_reg;
    outcome_t               outcome_next;
    logic signed [W-1:0]    sat_z;

    assign ent = ent_t'(pop_data);

    // advance the whole back end unless the result register is held
    assign adv = !hit_out.valid || hit_out.ready;
    assign pop = adv && !q_stat.empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            b3_valid_reg <= 1'b0;
            b4_valid_reg <= 1'b0;
            div_v[0]     <= 1'b0;
            e_valid_reg  <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else if (adv)
        begin
            b1_valid_reg <= !q_stat.empty;
            b2_valid_reg <= b1_valid_reg;
            b3_valid_reg <= b2_valid_reg;
            b4_valid_reg <= b3_valid_reg;
            div_v[0]     <= b4_valid_reg;
            e_valid_reg  <= div_v[Q];
            o_valid_reg  <= e_valid_reg;
        end
    end

    assign num_mag = num_reg[NUMW-1] ? NUMW'(-num_reg) : NUMW'(num_reg);

    // result sign and quotient range flag ride along with the side data
    always_comb
    begin
        b4_side_next     = b3_side_reg;
        b4_side_next.neg = num_reg[NUMW-1] ^ b3_side_reg.nz_neg;
        div_s0_next      = b4_side_reg;
        div_s0_next.ovf  = (b4_n_reg >= (R_W'(b4_d_reg) << Q));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pp_lx_reg <= NW'($signed({1'b0, ent.nx[S-1:0]})) * NW'(ent.px);
            pp_hx_reg <= NW'($signed(ent.nx[NW-1:S])) * NW'(ent.px);
            pp_ly_reg <= NW'($signed({1'b0, ent.ny[S-1:0]})) * NW'(ent.py);
            pp_hy_reg <= NW'($signed(ent.ny[NW-1:S])) * NW'(ent.py);
            b1_nz_reg <= ent.nz;
            b1_side_reg.cls    <= ent.cls;
            b1_side_reg.nz_neg <= ent.nz[NW-1];
            b1_side_reg.neg    <= 1'b0;
            b1_side_reg.ovf    <= 1'b0;
            b1_side_reg.v0z    <= ent.v0z;
            b1_side_reg.qz     <= ent.qz;

            sx_reg      <= (NUMW'(pp_hx_reg) <<< S) + NUMW'(pp_lx_reg);
            sy_reg      <= (NUMW'(pp_hy_reg) <<< S) + NUMW'(pp_ly_reg);
            b2_nz_reg   <= b1_nz_reg;
            b2_side_reg <= b1_side_reg;

            num_reg     <= sx_reg + sy_reg;
            den_reg     <= b2_nz_reg[NW-1] ? NW'(-b2_nz_reg) : NW'(b2_nz_reg);
            b3_side_reg <= b2_side_reg;

            // round half away from zero: (2|num| + den) / (2 den)
            b4_n_reg    <= R_W'({num_mag, 1'b0}) + R_W'(den_reg);
            b4_d_reg    <= {den_reg, 1'b0};
            b4_side_reg <= b4_side_next;

            // a quotient beyond Q bits only needs to land outside any span
            div_r[0]     <= b4_n_reg;
            div_d[0]     <= b4_d_reg;
            div_s[0]     <= div_s0_next;
        end
    end

    assign div_q[0] = '0;

    for (genvar j = 0; j < Q; j++)
    begin : g_div
        localparam int K = Q - 1 - j;
        logic [R_W-1:0] sh;
        logic [R_W:0]   trial;

        assign sh    = R_W'(div_d[j]) << K;
        assign trial = {1'b0, div_r[j]} - {1'b0, sh};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                div_v[j+1] <= 1'b0;
            else if (adv)
                div_v[j+1] <= div_v[j];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                div_q[j+1] <= {div_q[j][Q-2:0], !trial[R_W]};
                div_s[j+1] <= div_s[j];
            end
        end

        if (j < Q - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    div_r[j+1] <= trial[R_W] ? div_r[j] : trial[R_W-1:0];
                    div_d[j+1] <= div_d[j];
                end
            end
        end
    end

    assign qmag   = div_s[Q].ovf ? {1'b1, {Q{1'b0}}} : {1'b0, div_q[Q]};
    assign span_s = HB'($signed({1'b0, half_span}));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (div_s[Q].neg)
                h_reg <= HB'(div_s[Q].v0z) + HB'($signed({1'b0, qmag}));
            else
                h_reg <= HB'(div_s[Q].v0z) - HB'($signed({1'b0, qmag}));
            lo_reg    <= HB'(div_s[Q].qz) - span_s;
            hi_reg    <= HB'(div_s[Q].qz) + span_s;
            e_cls_reg <= div_s[Q].cls;

            o_hit_reg     <= (outcome_next == OUT_HIT);
            o_z_reg       <= (outcome_next == OUT_HIT) ? sat_z : '0;
            o_outcome_reg <= outcome_next;
        end
    end

    always_comb
    begin
        priority if (e_cls_reg == CLS_OUTSIDE)
            outcome_next = OUT_OUTSIDE;
        else if (e_cls_reg == CLS_DEGEN)
            outcome_next = OUT_DEGEN;
        else if (h_reg > hi_reg)
            outcome_next = OUT_ABOVE;
        else if (h_reg < lo_reg)
            outcome_next = OUT_BELOW;
        else
            outcome_next = OUT_HIT;
    end

    // clamp to the coordinate range when the upper bits are not all sign
    always_comb
    begin
        if ((&h_reg[HB-1:W-1]) || !(|h_reg[HB-1:W-1]))
            sat_z = h_reg[W-1:0];
        else if (h_reg[HB-1])
            sat_z = {1'b1, {(W-1){1'b0}}};
        else
            sat_z = {1'b0, {(W-1){1'b1}}};
    end

    assign hit_out.valid   = o_valid_reg;
    assign hit_out.hit     = o_hit_reg;
    assign hit_out.hit_z   = o_z_reg;
    assign hit_out.outcome = o_outcome_reg;

endmodule

// ===== rtl/vertical_ray_triangle_hit.sv =====
// ----------------------------------------------------------------------------
// vertical_ray_triangle_hit
// Tests a vertical segment through a query point against one triangle a word.
// ----------------------------------------------------------------------------
// Each input word carries a triangle and a query point in signed fixed point;
// each one gives exactly one result word with a hit flag, the plane height at
// the query point and a reason code (hit, outside the edges, degenerate
// plane, below or above the span query_z +/- half_span). The block takes one
// word every cycle unless a stalled output has filled the queue. The rounding
// divide resolves one quotient bit per pipeline stage over max(COORD_BITS, 24)
// + 4 stages. A three-stage front end computes edge functions and the plane
// normal and feeds a four-word queue, so a stalled output only holds the front
// end once the queue fills. The half_span register (byte address 0, reset 100
// units) may be written only while no word is in flight.
// ----------------------------------------------------------------------------
module vertical_ray_triangle_hit #(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [vrth_pkg::ADDR_W-1:0]  paddr,
    input  logic [vrth_pkg::DATA_W-1:0]  pwdata,
    output logic [vrth_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    vrth_in_if.sink                      tri_in,
    vrth_out_if.source                   hit_out
);
    import vrth_pkg::*;

    localparam int DW    = COORD_BITS + 1;
    localparam int NW    = 2 * DW + 1;
    localparam int ENT_W = 2 + 3 * NW + 2 * DW + 2 * COORD_BITS;
    localparam logic [SPAN_W-1:0] SPAN_RST = SPAN_W'(SPAN_UNITS << FRAC_BITS);

    logic [SPAN_W-1:0] half_span_reg;
    logic              reg_sel;
    logic              q_push, q_pop;
    logic [ENT_W-1:0]  q_push_data, q_pop_data;
    q_stat_t           q_stat;

    // register decode: word index sits above the byte offset
    assign reg_sel = (paddr[ADDR_W-1:REG_IDX_LSB] == REG_HALF_SPAN);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {{(DATA_W-SPAN_W){1'b0}}, half_span_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            half_span_reg <= SPAN_RST;
        else if (psel && penable && pwrite && reg_sel)
            half_span_reg <= pwdata[SPAN_W-1:0];
    end

    // front end: classify and build queue words
    vrth_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .tri_in    (tri_in),
        .push      (q_push),
        .push_data (q_push_data),
        .q_stat    (q_stat)
    );

    // decoupling queue
    vrth_queue #(
        .DATA_W (ENT_W),
        .DEPTH  (4)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .q_stat    (q_stat)
    );

    // back end: divide, span test, result register
    vrth_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .half_span (half_span_reg),
        .q_stat    (q_stat),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .hit_out   (hit_out)
    );

`ifndef SYNTHESIS
    a_hit_code: assert property (@(posedge clk) disable iff (!rst_n)
        hit_out.valid |-> (hit_out.hit == (hit_out.outcome == OUT_HIT)))
        else $error("hit flag disagrees with reason code");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (hit_out.valid && !hit_out.hit) |-> (hit_out.hit_z == '0))
        else $error("miss carries nonzero height");

    a_stall_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (hit_out.valid && !hit_out.ready) |-> !q_pop)
        else $error("queue popped while result held");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        hit_out.valid |-> (hit_out.outcome <= OUT_ABOVE))
        else $error("reason code out of range");
`endif

endmodule

// ===== bench/vrth_checker.sv =====
// ----------------------------------------------------------------------------
// vrth_checker
// Predicts and checks every result word of the vertical ray / triangle block.
// ----------------------------------------------------------------------------
// Watches the triangle and result channels. Each accepted triangle word is
// run through an exact integer model of the hit test, and the expected result
// is queued. Each accepted result word is compared with the oldest one.
// ----------------------------------------------------------------------------
module vrth_checker
    import vrth_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [23:0] half_span,
    vrth_in_if          tri_in,
    vrth_out_if         hit_out,
    output int          errors,
    output int          pending,
    output int          hits_seen
);

    typedef struct packed {
        logic             hit;
        logic [31:0]      hit_z;
        outcome_t         outcome;
    } hit_result_t;

    hit_result_t expected_hits[$];

    // exact 2D edge function, widths chosen so nothing can overflow
    function automatic logic signed [127:0] edge_fn(
        logic signed [127:0] ax, logic signed [127:0] ay,
        logic signed [127:0] bx, logic signed [127:0] by,
        logic signed [127:0] qx, logic signed [127:0] qy);
        return (bx - ax) * (qy - ay) - (by - ay) * (qx - ax);
    endfunction

    function automatic hit_result_t predict_hit(
        logic signed [31:0] c[12], logic [23:0] span);
        logic signed [255:0] p[12];
        logic signed [255:0] e1x, e1y, e1z, e2x, e2y, e2z, nx, ny, nz;
        logic signed [255:0] num, den, anum, q, h, lo, hi;
        hit_result_t r;
        for (int i = 0; i < 12; i++)
            p[i] = c[i];
        r.hit = 1'b0;
        r.hit_z = '0;
        if (edge_fn(p[0], p[1], p[3], p[4], p[9], p[10]) < 0 ||
            edge_fn(p[3], p[4], p[6], p[7], p[9], p[10]) < 0 ||
            edge_fn(p[6], p[7], p[0], p[1], p[9], p[10]) < 0)
        begin
            r.outcome = OUT_OUTSIDE;
            return r;
        end
        e1x = p[3] - p[0]; e1y = p[4] - p[1]; e1z = p[5] - p[2];
        e2x = p[6] - p[0]; e2y = p[7] - p[1]; e2z = p[8] - p[2];
        nx = e1y * e2z - e1z * e2y;
        ny = e1z * e2x - e1x * e2z;
        nz = e1x * e2y - e1y * e2x;
        if (nz == 0)
        begin
            r.outcome = OUT_DEGEN;
            return r;
        end
        num = nx * (p[9] - p[0]) + ny * (p[10] - p[1]);
        den = (nz < 0) ? -nz : nz;
        anum = (num < 0) ? -num : num;
        // round half away from zero on the magnitude
        q = (2 * anum + den) / (2 * den);
        if ((num < 0) != (nz < 0))
            q = -q;
        h = p[2] - q;
        lo = p[11] - $signed({1'b0, span});
        hi = p[11] + $signed({1'b0, span});
        if (h > hi)
            r.outcome = OUT_ABOVE;
        else if (h < lo)
            r.outcome = OUT_BELOW;
        else
        begin
            r.outcome = OUT_HIT;
            r.hit = 1'b1;
            if (h > 256'sd2147483647)
                h = 256'sd2147483647;
            if (h < -256'sd2147483648)
                h = -256'sd2147483648;
            r.hit_z = h[31:0];
        end
        return r;
    endfunction

    assign pending = expected_hits.size();

    always @(posedge clk or negedge rst_n)
    begin
        logic signed [31:0] c[12];
        hit_result_t got, want;
        if (!rst_n)
        begin
            errors <= 0;
            hits_seen <= 0;
            expected_hits.delete();
        end
        else
        begin
            if (tri_in.valid && tri_in.ready)
            begin
                c = '{tri_in.v0_x, tri_in.v0_y, tri_in.v0_z, tri_in.v1_x, tri_in.v1_y,
                      tri_in.v1_z, tri_in.v2_x, tri_in.v2_y, tri_in.v2_z,
                      tri_in.query_x, tri_in.query_y, tri_in.query_z};
                expected_hits.push_back(predict_hit(c, half_span));
            end
            if (hit_out.valid && hit_out.ready)
            begin
                got.hit = hit_out.hit;
                got.hit_z = hit_out.hit_z;
                got.outcome = outcome_t'(hit_out.outcome);
                if (got.hit)
                    hits_seen <= hits_seen + 1;
                if (expected_hits.size() == 0)
                begin
                    $display("%0t: unexpected result word hit=%0b hit_z=%0d outcome=%0d",
                             $time, got.hit, $signed(got.hit_z), got.outcome);
                    errors <= errors + 1;
                end
                else
                begin
                    want = expected_hits.pop_front();
                    if (got.hit !== want.hit || got.hit_z !== want.hit_z ||
                        got.outcome !== want.outcome)
                    begin
                        $display("%0t: expected hit=%0b hit_z=%0d outcome=%0d, got hit=%0b hit_z=%0d outcome=%0d",
                                 $time, want.hit, $signed(want.hit_z), want.outcome,
                                 got.hit, $signed(got.hit_z), got.outcome);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the vertical ray / triangle hit block.
// ----------------------------------------------------------------------------
// Writes the half span register over APB between phases, sends directed and
// random triangles with random gaps on both channels, and leaves all checking
// to vrth_checker.
// ----------------------------------------------------------------------------
module testbench;
    import vrth_pkg::*;

    localparam int LATENCY   = 47;
    localparam int MAX_CYCLES = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;
    logic [23:0] span_now = 24'(SPAN_UNITS << 8);
    int errors, pending, hits_seen;
    int words_sent = 0;
    int cycle = 0;

    vrth_in_if  tri_in ();
    vrth_out_if hit_out ();

    vertical_ray_triangle_hit u_top (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .tri_in(tri_in.sink), .hit_out(hit_out.source)
    );

    vrth_checker u_check (
        .clk(clk), .rst_n(rst_n), .half_span(span_now), .tri_in(tri_in),
        .hit_out(hit_out), .errors(errors), .pending(pending), .hits_seen(hits_seen)
    );

    always #6 clk = ~clk;

    // watchdog: a stuck handshake ends the run as a failure
    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLES)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side: before each word, hold ready low for a random gap,
    // with quiet stretches where ready stays high
    initial
    begin
        int gap;
        hit_out.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            @(negedge clk);
            hit_out.ready <= 1'b0;
            repeat (gap) @(negedge clk);
            hit_out.ready <= 1'b1;
            do @(posedge clk); while (!hit_out.valid);
        end
    end

    // the register takes effect at the access edge; the checker follows it
    task automatic write_span(logic [23:0] value);
        @(negedge clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= ADDR_W'(REG_HALF_SPAN) << REG_IDX_LSB;
        pwdata <= DATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        span_now <= value;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // send one word, honoring the idle gap drawn for it; valid stays high
    // into the next word when that word has no gap
    task automatic send_word(logic signed [31:0] c[12], int gap);
        if (gap != 0)
        begin
            tri_in.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        tri_in.valid <= 1'b1;
        {tri_in.v0_x, tri_in.v0_y, tri_in.v0_z, tri_in.v1_x, tri_in.v1_y, tri_in.v1_z,
         tri_in.v2_x, tri_in.v2_y, tri_in.v2_z, tri_in.query_x, tri_in.query_y,
         tri_in.query_z} <= {c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8],
                             c[9], c[10], c[11]};
        do @(posedge clk); while (!tri_in.ready);
        words_sent++;
        @(negedge clk);
    endtask

    function automatic int pick_gap();
        return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9);
    endfunction

    function automatic logic signed [31:0] rnd_coord(int scale);
        case (scale)
            0: return $signed(32'($urandom_range(0, 64))) - 32;
            1: return $signed(32'($urandom_range(0, 131072))) - 65536;
            2: return $signed(32'($urandom_range(0, 33554432))) - 16777216;
            default: return $signed(32'($urandom()));
        endcase
    endfunction

    // random, mostly counter-clockwise triangle with the query near or inside it,
    // so most words get past the edge test
    function automatic void make_random(ref logic signed [31:0] c[12]);
        int scale;
        logic signed [63:0] ex;
        logic signed [31:0] t;
        scale = $urandom_range(0, 9);
        scale = (scale < 3) ? 0 : (scale < 6) ? 1 : (scale < 9) ? 2 : 3;
        for (int i = 0; i < 9; i++)
            c[i] = rnd_coord(scale);
        ex = (c[3] - c[0]) * (c[7] - c[1]) - (c[4] - c[1]) * (c[6] - c[0]);
        if (ex < 0 && $urandom_range(0, 7) != 0)
        begin
            t = c[3]; c[3] = c[6]; c[6] = t;
            t = c[4]; c[4] = c[7]; c[7] = t;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            c[6] = c[3]; c[7] = c[4];  // zero-area sliver
        end
        case ($urandom_range(0, 4))
            0: begin c[9] = rnd_coord(scale); c[10] = rnd_coord(scale); end
            1: begin c[9] = c[3]; c[10] = c[4]; end
            default:
            begin
                c[9]  = 32'((64'(c[0]) + 64'(c[3]) + 64'(c[6])) / 3);
                c[10] = 32'((64'(c[1]) + 64'(c[4]) + 64'(c[7])) / 3);
            end
        endcase
        c[11] = (scale == 3) ? rnd_coord(3) : c[2] + rnd_coord(scale);
    endfunction

    // drop valid, then wait for every word to come out
    task automatic wait_idle();
        tri_in.valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    initial
    begin
        logic signed [31:0] c[12];
        logic [23:0] spans[5];
        tri_in.valid = 1'b0;
        {tri_in.v0_x, tri_in.v0_y, tri_in.v0_z, tri_in.v1_x, tri_in.v1_y, tri_in.v1_z,
         tri_in.v2_x, tri_in.v2_y, tri_in.v2_z, tri_in.query_x, tri_in.query_y,
         tri_in.query_z} = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed words at the reset span: hit, edge and vertex points,
        // outside, vertical and zero-area planes, above and below, extremes
        c = '{0, 0, 0, 2560, 0, 0, 0, 2560, 0, 256, 256, 0};
        send_word(c, 0);                                 // flat hit
        c[9] = 0; c[10] = 0; send_word(c, 0);            // on a vertex
        c[9] = 1280; c[10] = 0; send_word(c, 1);         // on an edge
        c[9] = 2560; c[10] = 2560; send_word(c, 0);      // outside
        c = '{0, 0, 0, 0, 2560, 0, 2560, 0, 0, 256, 256, 0};
        send_word(c, 0);                                 // clockwise winding
        c = '{0, 0, 0, 256, 256, 256, 512, 512, 0, 256, 256, 0};
        send_word(c, 0);                                 // vertical triangle
        c = '{7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7};
        send_word(c, 0);                                 // single point
        c = '{0, 0, 30000, 2560, 0, 30000, 0, 2560, 30000, 256, 256, 0};
        send_word(c, 0);                                 // above span
        c[11] = 60000; send_word(c, 0);                  // below span
        c[11] = 30000 - 25600; send_word(c, 0);          // exactly at top bound
        c[11] = 30000 + 25600; send_word(c, 0);          // exactly at bottom bound
        c = '{0, 0, 0, 1, 0, 1, 0, 3, 0, 1, 1, 0};
        send_word(c, 2);                                 // query just outside the edges
        c = '{-2147483648, -2147483648, 2147483647, 2147483647, -2147483648,
              2147483647, -2147483648, 2147483647, -2147483648, 0, 0, 0};
        send_word(c, 0);                                 // full range, steep plane
        c = '{-2147483648, -2147483648, 2147483647, 2147483647, -2147483648,
              2147483647, -2147483648, 2147483647, 2147483647, 2147483647, 2147483647,
              2147483647};
        send_word(c, 0);                                 // corner of the range
        c = '{0, 0, 2147483647, 2, 0, -2147483648, 0, 2, -2147483648, 2, 0,
              2147483647};
        send_word(c, 0);                                 // height at the range minimum, below span
        c = '{0, 0, 0, 1, 0, 2147483647, 0, 1, -2147483648, 1, 0, -2147483648};
        send_word(c, 0);
        c = '{-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1};
        send_word(c, 0);
        wait_idle();

        // phases of random words over several spans, extremes included
        spans = '{24'd0, 24'hFFFFFF, 24'd1, 24'd256, 24'($urandom())};
        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph > 0)
                write_span(spans[ph - 1]);
            if (ph == 0)
            begin
                c = '{0, 0, 512, 2560, 0, 512, 0, 2560, 512, 256, 256, 512};
                send_word(c, 0);
            end
            for (int n = 0; n < 300; n++)
            begin
                make_random(c);
                send_word(c, pick_gap());
            end
            wait_idle();
        end

        $display("Sent %0d triangle words over six span settings; %0d result words were hits.",
                 words_sent, hits_seen);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/vrth_pkg.sv
rtl/vrth_in_if.sv
rtl/vrth_out_if.sv
rtl/vrth_front.sv
rtl/vrth_queue.sv
rtl/vrth_back.sv
rtl/vertical_ray_triangle_hit.sv
bench/vrth_checker.sv
bench/testbench.sv
